// ===== rtl/scf_pkg.sv =====
// shared types and constants of the cross sharpen filter
// no dependencies
`timescale 1ns / 1ps

package scf_pkg;

    // default sizing
    localparam int DEF_MAX_WIDTH    = 2048;
    localparam int DEF_MAX_CHANNELS = 4;

    // configuration register indexes
    localparam logic [1:0] REG_IMAGE_WIDTH   = 2'd0;
    localparam logic [1:0] REG_IMAGE_HEIGHT  = 2'd1;
    localparam logic [1:0] REG_CHANNEL_COUNT = 2'd2;

    // register widths and reset values
    localparam int CFG_DATA_W  = 12;
    localparam int CHAN_W      = 3;
    localparam int MAX_HEIGHT  = 4095;
    localparam logic [11:0] RST_WIDTH    = 12'd640;
    localparam logic [11:0] RST_HEIGHT   = 12'd480;
    localparam logic [2:0]  RST_CHANNELS = 3'd3;

    // input kind codes
    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_DRAIN  = 1'b1;

    // result queue sizing
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PW    = $clog2(QUEUE_DEPTH);

    // classification of one accepted request
    typedef struct packed {
        logic sample;
        logic produce;
        logic interior;
        logic last;
    } cmd_flags_t;

    // one result
    typedef struct packed {
        logic [7:0] pixel;
        logic       last;
    } result_t;

endpackage

// ===== rtl/scf_front.sv =====
// front part: configuration registers, raster position, drain count, classification
// depends on scf_pkg
`timescale 1ns / 1ps

module scf_front
    import scf_pkg::*;
#(
    parameter int MAX_WIDTH    = DEF_MAX_WIDTH,
    parameter int MAX_CHANNELS = DEF_MAX_CHANNELS,
    localparam int LW = $clog2(MAX_WIDTH * MAX_CHANNELS + 1),
    localparam int AW = $clog2(MAX_WIDTH * MAX_CHANNELS),
    localparam int DW = $clog2(MAX_WIDTH * MAX_CHANNELS + MAX_CHANNELS + 1)
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [1:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  accept,
    input  logic                  kind,
    output cmd_flags_t            flags,
    output logic [AW-1:0]         k_addr,
    output logic [AW-1:0]         j_addr,
    output logic [CHAN_W-1:0]     chan,
    output logic                  restart
);

    localparam int WW = $clog2(MAX_WIDTH + 1);

    logic [11:0]       width_reg, height_reg;
    logic [2:0]        chans_reg;
    logic [LW-1:0]     k_reg, k_next;
    logic [11:0]       r_reg, r_next;
    logic [DW-1:0]     drain_reg, drain_next;

    logic [WW-1:0]     w_eff;
    logic [11:0]       h_eff;
    logic [CHAN_W-1:0] c_eff;
    logic [LW-1:0]     line, k_use, j_full, k_inc;
    logic [11:0]       r_use, ro, r_inc;
    logic              ge_c, cond, is_sample, owed, inner, last_c;

    // clamp the registers to their usable ranges
    always_comb
    begin
        if (width_reg < 12'd3)
            w_eff = WW'(3);
        else if (32'(width_reg) > MAX_WIDTH)
            w_eff = WW'(MAX_WIDTH);
        else
            w_eff = WW'(width_reg);
        h_eff = (height_reg < 12'd3) ? 12'd3 : height_reg;
        if (chans_reg < 3'd1)
            c_eff = CHAN_W'(1);
        else if (32'(chans_reg) > MAX_CHANNELS)
            c_eff = CHAN_W'(MAX_CHANNELS);
        else
            c_eff = chans_reg;
        line = LW'(w_eff * c_eff);
    end

    // position of this request and of its result
    always_comb
    begin
        if (k_reg >= line || r_reg >= h_eff)
        begin
            k_use = '0;
            r_use = '0;
        end
        else
        begin
            k_use = k_reg;
            r_use = r_reg;
        end
        ge_c   = k_use >= LW'(c_eff);
        j_full = ge_c ? k_use - LW'(c_eff) : k_use + line - LW'(c_eff);
        cond   = (r_use >= 12'd2) || (r_use == 12'd1 && ge_c);
        ro     = ge_c ? r_use - 12'd1 : r_use - 12'd2;
        inner  = !(ro == 12'd0 || ro == h_eff - 12'd1 || j_full < LW'(c_eff)
                   || j_full >= line - LW'(c_eff));
        last_c = (ro == h_eff - 12'd1) && (j_full == line - LW'(1));
        is_sample = (kind == KIND_SAMPLE);
        owed   = !(is_sample && cond) && (drain_reg != '0);
        k_inc  = k_use + LW'(1);
        r_inc  = r_use + 12'd1;
    end

    // classification handed to the window path
    always_comb
    begin
        flags.sample   = is_sample;
        flags.produce  = (is_sample && cond) || (drain_reg != '0);
        flags.interior = is_sample && cond && inner;
        flags.last     = (is_sample && cond) ? last_c : (drain_reg == DW'(1));
        k_addr  = k_use[AW-1:0];
        j_addr  = j_full[AW-1:0];
        chan    = c_eff;
        restart = cfg_write && (cfg_index == REG_IMAGE_WIDTH
                  || cfg_index == REG_IMAGE_HEIGHT || cfg_index == REG_CHANNEL_COUNT);
    end

    // next raster position and owed zeros
    always_comb
    begin
        k_next     = k_reg;
        r_next     = r_reg;
        drain_next = drain_reg;
        if (restart)
        begin
            k_next     = '0;
            r_next     = '0;
            drain_next = '0;
        end
        else if (accept)
        begin
            if (owed)
                drain_next = drain_reg - DW'(1);
            if (is_sample)
            begin
                k_next = k_inc;
                r_next = r_use;
                if (k_inc == line)
                begin
                    k_next = '0;
                    r_next = r_inc;
                    if (r_inc == h_eff)
                    begin
                        r_next     = '0;
                        drain_next = DW'(line) + DW'(c_eff);
                    end
                end
            end
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= RST_WIDTH;
            height_reg <= RST_HEIGHT;
            chans_reg  <= RST_CHANNELS;
            k_reg      <= '0;
            r_reg      <= '0;
            drain_reg  <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_IMAGE_WIDTH:   width_reg  <= cfg_data;
                    REG_IMAGE_HEIGHT:  height_reg <= cfg_data;
                    REG_CHANNEL_COUNT: chans_reg  <= cfg_data[2:0];
                    default: ;
                endcase
            end
            k_reg     <= k_next;
            r_reg     <= r_next;
            drain_reg <= drain_next;
        end
    end

endmodule

// ===== rtl/scf_window.sv =====
// back part: line stores, sample windows and the sharpen arithmetic, two stages
// depends on scf_pkg
`timescale 1ns / 1ps

module scf_window
    import scf_pkg::*;
#(
    parameter int MAX_WIDTH    = DEF_MAX_WIDTH,
    parameter int MAX_CHANNELS = DEF_MAX_CHANNELS,
    localparam int AW = $clog2(MAX_WIDTH * MAX_CHANNELS)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic              restart,
    input  cmd_flags_t        flags,
    input  logic [AW-1:0]     k_addr,
    input  logic [AW-1:0]     j_addr,
    input  logic [CHAN_W-1:0] chan,
    input  logic [7:0]        sample_value,
    output logic              res_valid,
    output result_t           res,
    output logic [1:0]        inflight
);

    localparam int DEPTH = MAX_WIDTH * MAX_CHANNELS;
    localparam int LD    = MAX_CHANNELS + 1;
    localparam int MD    = 2 * MAX_CHANNELS + 1;
    localparam int LIW   = $clog2(LD);
    localparam int MIW   = $clog2(MD);

    logic [7:0] prev_mem  [DEPTH];
    logic [7:0] older_mem [DEPTH];
    logic [7:0] lower_reg [LD];
    logic [7:0] mid_reg   [MD];
    logic [7:0] prev_rd_reg;

    logic              s1_valid_reg, s2_valid_reg;
    cmd_flags_t        s1_flags_reg, s2_flags_reg;
    logic [AW-1:0]     s1_j_reg;
    logic [CHAN_W-1:0] s1_c_reg;
    logic [7:0]        s1_low_reg, s2_low_reg;
    logic [7:0]        s2_ctr_reg, s2_far_reg, s2_near_reg, up_reg;

    logic [7:0]  low_sel, mid_ctr, mid_far;
    logic [11:0] sum;
    logic        s1_shift;

    // lower neighbour is the window entry one pixel back after the shift
    assign low_sel  = lower_reg[LIW'(chan - CHAN_W'(1))];
    assign s1_shift = s1_valid_reg && s1_flags_reg.sample;
    assign mid_ctr  = mid_reg[MIW'(s1_c_reg - CHAN_W'(1))];
    assign mid_far  = mid_reg[MIW'({s1_c_reg, 1'b0} - 4'd1)];

    // previous row store, read before write
    always_ff @(posedge clk)
    begin
        if (accept && flags.sample)
        begin
            prev_rd_reg      <= prev_mem[k_addr];
            prev_mem[k_addr] <= sample_value;
        end
    end

    // older row store, takes the centre of the middle window at each shift
    always_ff @(posedge clk)
    begin
        if (s1_shift)
        begin
            up_reg              <= older_mem[s1_j_reg];
            older_mem[s1_j_reg] <= mid_ctr;
        end
    end

    // sample windows
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LD; i++)
                lower_reg[i] <= '0;
            for (int i = 0; i < MD; i++)
                mid_reg[i] <= '0;
        end
        else if (restart)
        begin
            for (int i = 0; i < LD; i++)
                lower_reg[i] <= '0;
            for (int i = 0; i < MD; i++)
                mid_reg[i] <= '0;
        end
        else
        begin
            if (accept && flags.sample)
            begin
                lower_reg[0] <= sample_value;
                for (int i = 1; i < LD; i++)
                    lower_reg[i] <= lower_reg[i-1];
            end
            if (s1_shift)
            begin
                mid_reg[0] <= prev_rd_reg;
                for (int i = 1; i < MD; i++)
                    mid_reg[i] <= mid_reg[i-1];
            end
        end
    end

    // stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        s1_flags_reg <= flags;
        s1_j_reg     <= j_addr;
        s1_c_reg     <= chan;
        s1_low_reg   <= low_sel;
        s2_flags_reg <= s1_flags_reg;
        s2_low_reg   <= s1_low_reg;
        s2_ctr_reg   <= mid_ctr;
        s2_far_reg   <= mid_far;
        s2_near_reg  <= prev_rd_reg;
    end

    // five times the centre less the four neighbours, saturated; border results are zero
    always_comb
    begin
        sum = ({4'd0, s2_ctr_reg} << 2) + {4'd0, s2_ctr_reg} - {4'd0, s2_far_reg}
              - {4'd0, s2_near_reg} - {4'd0, up_reg} - {4'd0, s2_low_reg};
        if (!s2_flags_reg.interior || sum[11])
            res.pixel = 8'd0;
        else if (sum > 12'd255)
            res.pixel = 8'd255;
        else
            res.pixel = sum[7:0];
        res.last  = s2_flags_reg.last;
        res_valid = s2_valid_reg && s2_flags_reg.produce;
        inflight  = 2'(s1_valid_reg && s1_flags_reg.produce) + 2'(res_valid);
    end

endmodule

// ===== rtl/scf_queue.sv =====
// result queue between the arithmetic and the consumer
// depends on scf_pkg
`timescale 1ns / 1ps

module scf_queue
    import scf_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr,
    input  result_t             wr_data,
    input  logic                pop,
    output logic                empty,
    output result_t             rd_data,
    output logic [QUEUE_PW:0]   count
);

    result_t               mem [QUEUE_DEPTH];
    logic [QUEUE_PW-1:0]   wp_reg, rp_reg;
    logic [QUEUE_PW:0]     count_reg;
    logic                  rd;

    assign empty   = (count_reg == '0);
    assign rd      = pop && !empty;
    assign rd_data = mem[rp_reg];
    assign count   = count_reg;

    // storage
    always_ff @(posedge clk)
    begin
        if (wr)
            mem[wp_reg] <= wr_data;
    end

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg    <= '0;
            rp_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (wr)
                wp_reg <= wp_reg + QUEUE_PW'(1);
            if (rd)
                rp_reg <= rp_reg + QUEUE_PW'(1);
            count_reg <= count_reg + (QUEUE_PW+1)'(wr) - (QUEUE_PW+1)'(rd);
        end
    end

endmodule

// ===== rtl/sharpen_3x3_cross_filter_core.sv =====
// Streaming 3x3 cross sharpen filter, one channel sample per request.
// Throughput: one request per cycle while full is low; a result enters the queue
// from the stage 2 registers of the window path, behind the registered line store reads.
// Pixel results lag the input by one row and one pixel of the image.
// Reset: asynchronous active low; registers take their defaults, windows and
// positions clear, line stores keep whatever they hold.
`timescale 1ns / 1ps

module sharpen_3x3_cross_filter_core
    import scf_pkg::*;
#(
    parameter int MAX_WIDTH    = DEF_MAX_WIDTH,
    parameter int MAX_CHANNELS = DEF_MAX_CHANNELS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [1:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  push,
    output logic                  full,
    input  logic                  kind,
    input  logic [7:0]            sample_value,
    output logic                  empty,
    input  logic                  pop,
    output logic [7:0]            pixel_out,
    output logic                  frame_last
);

    localparam int AW = $clog2(MAX_WIDTH * MAX_CHANNELS);

    cmd_flags_t        flags;
    logic [AW-1:0]     k_addr, j_addr;
    logic [CHAN_W-1:0] chan;
    logic              restart, accept, res_valid;
    result_t           res, head;
    logic [1:0]        inflight;
    logic [QUEUE_PW:0] count;

    // room for every result still in flight plus this one
    assign full   = (32'(count) + 32'(inflight)) >= QUEUE_DEPTH;
    assign accept = push && !full;

    scf_front #(
        .MAX_WIDTH    (MAX_WIDTH),
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .kind      (kind),
        .flags     (flags),
        .k_addr    (k_addr),
        .j_addr    (j_addr),
        .chan      (chan),
        .restart   (restart)
    );

    scf_window #(
        .MAX_WIDTH    (MAX_WIDTH),
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_window (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .restart      (restart),
        .flags        (flags),
        .k_addr       (k_addr),
        .j_addr       (j_addr),
        .chan         (chan),
        .sample_value (sample_value),
        .res_valid    (res_valid),
        .res          (res),
        .inflight     (inflight)
    );

    scf_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (res_valid),
        .wr_data (res),
        .pop     (pop),
        .empty   (empty),
        .rd_data (head),
        .count   (count)
    );

    assign pixel_out  = head.pixel;
    assign frame_last = head.last;

endmodule

// ===== sim/sharpen_3x3_cross_filter_core_tb.sv =====
// Regression bench for the streaming 3x3 cross sharpen filter core.
// Depends on scf_pkg and sharpen_3x3_cross_filter_core; self-checking against
// an in-bench predictor of the filter, with random idling on both queue sides.
`timescale 1ns / 1ps

module sharpen_3x3_cross_filter_core_tb;
    import scf_pkg::*;

    localparam int STORE_DEPTH = DEF_MAX_WIDTH * DEF_MAX_CHANNELS;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_write;
    logic [1:0]            cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  push;
    logic                  full;
    logic                  kind;
    logic [7:0]            sample_value;
    logic                  empty;
    logic                  pop;
    logic [7:0]            pixel_out;
    logic                  frame_last;

    sharpen_3x3_cross_filter_core uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .push         (push),
        .full         (full),
        .kind         (kind),
        .sample_value (sample_value),
        .empty        (empty),
        .pop          (pop),
        .pixel_out    (pixel_out),
        .frame_last   (frame_last)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // filter state mirrored by the bench
    logic [11:0] width_reg;
    logic [11:0] height_reg;
    logic [2:0]  chan_reg;
    logic [7:0]  prev_line [STORE_DEPTH];
    logic [7:0]  older_line [STORE_DEPTH];
    logic [7:0]  mid_win [2*DEF_MAX_CHANNELS+1];
    logic [7:0]  low_win [DEF_MAX_CHANNELS+1];
    int          col_pos;
    int          row_pos;
    int          zeros_owed;

    result_t     expected_pixels [$];
    int          errors;
    int          requests_sent;
    int          pixels_checked;
    int          frames_sent;
    int          tx_max;
    int          rx_max;
    int          rx_hold;

    // error reporting
    task automatic report(input string what);
        errors++;
        $display("mismatch at %0t ns: %s", $time, what);
    endtask

    function automatic int geom_width();
        return (width_reg < 3) ? 3 : (width_reg > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : width_reg;
    endfunction

    function automatic int geom_height();
        return (height_reg < 3) ? 3 : height_reg;
    endfunction

    function automatic int geom_chans();
        return (chan_reg < 1) ? 1 : (chan_reg > DEF_MAX_CHANNELS) ? DEF_MAX_CHANNELS : chan_reg;
    endfunction

    // frame restart on any register write
    function automatic void restart_frame();
        foreach (mid_win[i]) mid_win[i] = '0;
        foreach (low_win[i]) low_win[i] = '0;
        col_pos = 0;
        row_pos = 0;
        zeros_owed = 0;
    endfunction

    function automatic void give_owed_zero();
        result_t res;
        if (zeros_owed != 0)
        begin
            res.pixel = '0;
            res.last  = (zeros_owed == 1);
            expected_pixels.push_back(res);
            zeros_owed--;
        end
    endfunction

    // expected results of one accepted request
    function automatic void predict_sharpen(input logic k_in, input logic [7:0] v);
        int      w;
        int      h;
        int      c;
        int      line;
        int      k;
        int      r;
        int      j;
        int      ro;
        int      s;
        logic [7:0] up;
        result_t res;
        w = geom_width();
        h = geom_height();
        c = geom_chans();
        line = w * c;
        if (k_in == KIND_DRAIN)
        begin
            give_owed_zero();
            return;
        end
        k = col_pos;
        r = row_pos;
        if (k >= line || r >= h)
        begin
            k = 0;
            r = 0;
        end
        for (int i = 2*DEF_MAX_CHANNELS; i > 0; i--) mid_win[i] = mid_win[i-1];
        mid_win[0] = prev_line[k];
        prev_line[k] = v;
        for (int i = DEF_MAX_CHANNELS; i > 0; i--) low_win[i] = low_win[i-1];
        low_win[0] = v;
        // column of the result, one pixel back
        j = (k >= c) ? k - c : k + line - c;
        up = older_line[j];
        older_line[j] = mid_win[c];
        if (r >= 2 || (r == 1 && k >= c))
        begin
            ro = (k >= c) ? r - 1 : r - 2;
            s = 0;
            if (!(ro == 0 || ro == h - 1 || j < c || j >= line - c))
            begin
                s = 5 * int'(mid_win[c]) - int'(mid_win[2*c]) - int'(mid_win[0])
                    - int'(up) - int'(low_win[c]);
                if (s < 0) s = 0;
                if (s > 255) s = 255;
            end
            res.pixel = s[7:0];
            res.last  = (ro == h - 1 && j == line - 1);
            expected_pixels.push_back(res);
        end
        else
        begin
            give_owed_zero();
        end
        k++;
        if (k == line)
        begin
            k = 0;
            r++;
            if (r == h)
            begin
                r = 0;
                zeros_owed = line + c;
            end
        end
        col_pos = k;
        row_pos = r;
    endfunction

    // send one request, returns at the falling edge after acceptance
    task automatic send_request(input logic k_in, input logic [7:0] v);
        int gap;
        gap = $urandom_range(tx_max, 0);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        push         <= 1'b1;
        kind         <= k_in;
        sample_value <= v;
        // full is steady between falling and rising edge
        while (full) @(negedge clk);
        @(posedge clk);
        predict_sharpen(k_in, v);
        requests_sent++;
        @(negedge clk);
    endtask

    // stop offering and wait until every expected result has come
    task automatic settle();
        push <= 1'b0;
        while (expected_pixels.size() != 0) @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_write <= 1'b0;
        case (idx)
            REG_IMAGE_WIDTH:   width_reg  = val;
            REG_IMAGE_HEIGHT:  height_reg = val;
            REG_CHANNEL_COUNT: chan_reg   = val[CHAN_W-1:0];
            default: ;
        endcase
        restart_frame();
        @(negedge clk);
    endtask

    task automatic set_geometry(input int w, input int h, input int c);
        write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(w));
        write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(h));
        write_reg(REG_CHANNEL_COUNT, CFG_DATA_W'(c));
    endtask

    // one frame of samples with optional stray drain ticks, then its drain if asked for
    task automatic send_frame(input int samples, input bit noise, input bit drain);
        logic [7:0] v;
        for (int n = 0; n < samples; n++)
        begin
            if (noise && $urandom_range(15, 0) == 0) send_request(KIND_DRAIN, 8'($urandom));
            case ($urandom_range(5, 0))
                0:       v = 8'd0;
                1:       v = 8'd255;
                default: v = 8'($urandom);
            endcase
            send_request(KIND_SAMPLE, v);
        end
        frames_sent++;
        if (drain)
        begin
            for (int n = 0; n < geom_width() * geom_chans() + geom_chans() + 2; n++)
                send_request(KIND_DRAIN, 8'($urandom));
        end
    endtask

    // result checker
    initial
    begin
        int gap;
        result_t want;
        logic [7:0] got_pixel;
        logic       got_last;
        pop <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            gap = $urandom_range(rx_max, 0);
            if (rx_hold > 0)
            begin
                gap = rx_hold;
                rx_hold = 0;
            end
            if (gap > 0)
            begin
                pop <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            pop <= 1'b1;
            // head of the queue is steady until the accepting rising edge
            while (empty) @(negedge clk);
            got_pixel = pixel_out;
            got_last  = frame_last;
            @(posedge clk);
            pixels_checked++;
            if (expected_pixels.size() == 0)
            begin
                report($sformatf("unexpected result pixel %0d", got_pixel));
            end
            else
            begin
                want = expected_pixels.pop_front();
                if (got_pixel !== want.pixel)
                    report($sformatf("pixel_out %0d, expected %0d", got_pixel, want.pixel));
                if (got_last !== want.last)
                    report($sformatf("frame_last %0b, expected %0b", got_last, want.last));
            end
        end
    end

    // hand-built frames: clamp high, clamp low, owed zeros and stray drains
    task automatic test_directed();
        logic [7:0] bright_centre [9] = '{8'd0, 8'd0, 8'd0, 8'd0, 8'd255,
                                         8'd0, 8'd0, 8'd0, 8'd0};
        logic [7:0] dark_centre [9]   = '{8'd255, 8'd255, 8'd255, 8'd255, 8'd0,
                                         8'd255, 8'd255, 8'd255, 8'd255};
        set_geometry(3, 3, 1);
        send_request(KIND_DRAIN, 8'h5a);
        foreach (bright_centre[i]) send_request(KIND_SAMPLE, bright_centre[i]);
        // next frame starts without drain, so its first samples give owed zeros
        for (int i = 0; i < 9; i++)
        begin
            if (i == 4) send_request(KIND_DRAIN, 8'ha5);
            send_request(KIND_SAMPLE, dark_centre[i]);
        end
        for (int i = 0; i < 5; i++) send_request(KIND_DRAIN, 8'hff);
        settle();
    endtask

    // register extremes and out-of-range values
    task automatic test_register_limits();
        set_geometry(0, 0, 0);
        send_frame(9, 1'b0, 1'b1);
        settle();
        set_geometry(3, 4, 7);
        send_frame(48, 1'b1, 1'b1);
        settle();
        tx_max = 0;
        rx_max = 0;
        // widest rows: the first row alone gives nothing
        set_geometry(4095, 3, 1);
        send_frame(40, 1'b0, 1'b0);
        settle();
        // tallest frame, first rows only
        set_geometry(3, 4095, 1);
        send_frame(60, 1'b0, 1'b0);
        settle();
        tx_max = 14;
        rx_max = 14;
    endtask

    // receiver holds off long enough for the block to fill and stall
    task automatic test_backpressure();
        set_geometry(8, 4, 2);
        rx_hold = 300;
        tx_max = 0;
        send_frame(64, 1'b0, 1'b1);
        tx_max = 14;
        settle();
    endtask

    // register writes drop owed zeros and restart a frame midway
    task automatic test_restart();
        set_geometry(5, 4, 2);
        send_frame(40, 1'b0, 1'b0);
        settle();
        write_reg(REG_IMAGE_WIDTH, 5);
        send_frame(23, 1'b0, 1'b0);
        settle();
        write_reg(REG_IMAGE_HEIGHT, 4);
        send_frame(40, 1'b1, 1'b1);
        settle();
    endtask

    // random geometries, mostly whole frames, with varied idling
    task automatic test_random();
        int w;
        int h;
        int c;
        int stop_at;
        stop_at = requests_sent + 380;
        while (requests_sent < stop_at)
        begin
            w = $urandom_range(8, 3);
            h = $urandom_range(6, 3);
            c = $urandom_range(4, 1);
            set_geometry(w, h, c);
            for (int f = 0; f < $urandom_range(2, 1); f++)
            begin
                case ($urandom_range(2, 0))
                    0: tx_max = 0;
                    1: tx_max = 3;
                    default: tx_max = 14;
                endcase
                case ($urandom_range(2, 0))
                    0: rx_max = 0;
                    1: rx_max = 3;
                    default: rx_max = 14;
                endcase
                if ($urandom_range(5, 0) == 0)
                    send_frame($urandom_range(w * h * c - 1, 1), 1'b1, 1'b0);
                else
                    send_frame(w * h * c, 1'b1, $urandom_range(1, 0));
            end
            settle();
        end
    endtask

    // main sequence
    initial
    begin
        errors = 0;
        requests_sent = 0;
        pixels_checked = 0;
        frames_sent = 0;
        tx_max = 14;
        rx_max = 14;
        rx_hold = 0;
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = REG_IMAGE_WIDTH;
        cfg_data = '0;
        push = 1'b0;
        kind = KIND_SAMPLE;
        sample_value = '0;
        width_reg = RST_WIDTH;
        height_reg = RST_HEIGHT;
        chan_reg = RST_CHANNELS;
        foreach (prev_line[i]) prev_line[i] = '0;
        foreach (older_line[i]) older_line[i] = '0;
        restart_frame();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_register_limits();
        test_backpressure();
        test_restart();
        test_random();

        $display("covered %0d requests over %0d frames, %0d results checked",
                 requests_sent, frames_sent, pixels_checked);
        $display("geometry extremes, clamped registers, restarts and full-queue stalls included");
        if (errors == 0)
            $display("sharpen_3x3_cross_filter_core regression: pass");
        else
            $display("sharpen_3x3_cross_filter_core regression: fail");
        $finish;
    end

    // run limit
    initial
    begin
        #5000000;
        $display("timeout with %0d results still expected", expected_pixels.size());
        $display("sharpen_3x3_cross_filter_core regression: fail");
        $finish;
    end

endmodule
